[rtl/wsfe_pkg.sv]
// Shared types, constants and helper functions of the WebSocket frame encoder.
package wsfe_pkg;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME   = 8'd1;

  localparam logic [31:0] MAX_FRAME_RESET   = 32'd8192;
  localparam logic [31:0] MASK_KEY_ZERO_SUB = 32'h5555_5555;
  localparam logic [7:0]  FIN_BIT           = 8'h80;
  localparam logic [31:0] LEN7_MAX          = 32'd125;
  localparam logic [31:0] LEN16_MAX         = 32'd65535;
  localparam logic [6:0]  LEN_CODE_16       = 7'd126;
  localparam logic [6:0]  LEN_CODE_64       = 7'd127;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_PAY  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_PAY,
    CMD_ERR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    LEN_7,
    LEN_16,
    LEN_64
  } len_sel_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  opcode;
    logic [31:0] payload_len;
    logic [31:0] mask_key;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       error_too_long;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // One queued job: a header burst, a finished payload byte or a refusal.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  opcode;
    len_sel_t    len_sel;
    logic        mask;
    logic [31:0] plen;
    logic [31:0] key;
    logic [7:0]  data;
    logic        fend;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_stat_t;

  // Byte idx of a 32-bit word, most significant first.
  function automatic logic [7:0] key_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [3:0] ext_len(input len_sel_t sel);
    logic [3:0] n;
    unique case (sel)
      LEN_16:  n = 4'd2;
      LEN_64:  n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/wsfe_front.sv]
// Front end: configuration registers, frame state and classification of input words.
module wsfe_front import wsfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  q_stat_t              q_stat,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic        mask_en_r, mask_en_nxt;
  logic [31:0] max_r, max_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        open_r, open_nxt;

  logic        accept;
  logic        gt125, gt65535;
  logic [3:0]  extra;
  logic [32:0] total;
  logic        too_long;
  logic [31:0] eff_key;
  len_sel_t    len_sel;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;

  always_comb begin
    mask_en_nxt = mask_en_r;
    max_nxt     = max_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MASK_ENABLE: mask_en_nxt = cfg_data[0];
        CFG_MAX_FRAME:   max_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    gt125   = in_data.payload_len > LEN7_MAX;
    gt65535 = in_data.payload_len > LEN16_MAX;
    extra   = 4'd2 + (gt125 ? 4'd2 : 4'd0) + (gt65535 ? 4'd6 : 4'd0)
              + (mask_en_r ? 4'd4 : 4'd0);
    total    = {1'b0, in_data.payload_len} + {29'd0, extra};
    too_long = total >= {1'b0, max_r};
    eff_key  = (in_data.mask_key == 32'd0) ? MASK_KEY_ZERO_SUB : in_data.mask_key;
    len_sel  = gt65535 ? LEN_64 : (gt125 ? LEN_16 : LEN_7);

    rem_nxt   = rem_r;
    key_nxt   = key_r;
    phase_nxt = phase_r;
    open_nxt  = open_r;
    q_push    = 1'b0;

    q_cmd.kind    = CMD_HDR;
    q_cmd.opcode  = in_data.opcode;
    q_cmd.len_sel = len_sel;
    q_cmd.mask    = mask_en_r;
    q_cmd.plen    = in_data.payload_len;
    q_cmd.key     = eff_key;
    q_cmd.data    = in_data.data_byte ^ key_byte(key_r, phase_r);
    q_cmd.fend    = (rem_r == 32'd1);

    if (accept) begin
      if (in_data.req_type == REQ_START) begin
        q_push = 1'b1;
        phase_nxt = 2'd0;
        if (too_long) begin
          q_cmd.kind = CMD_ERR;
          open_nxt   = 1'b0;
          rem_nxt    = 32'd0;
          key_nxt    = 32'd0;
        end else begin
          q_cmd.kind = CMD_HDR;
          q_cmd.fend = (in_data.payload_len == 32'd0);
          key_nxt    = mask_en_r ? eff_key : 32'd0;
          rem_nxt    = in_data.payload_len;
          open_nxt   = (in_data.payload_len != 32'd0);
        end
      end else if (open_r && rem_r != 32'd0) begin
        q_push     = 1'b1;
        q_cmd.kind = CMD_PAY;
        rem_nxt    = rem_r - 32'd1;
        phase_nxt  = phase_r + 2'd1;
        if (rem_r == 32'd1) open_nxt = 1'b0;
      end else begin
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_en_r <= 1'b0;
      max_r     <= MAX_FRAME_RESET;
      rem_r     <= 32'd0;
      key_r     <= 32'd0;
      phase_r   <= 2'd0;
      open_r    <= 1'b0;
    end else begin
      mask_en_r <= mask_en_nxt;
      max_r     <= max_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      phase_r   <= phase_nxt;
      open_r    <= open_nxt;
    end
  end

endmodule

[rtl/wsfe_queue.sv]
// Short command queue between the front end and the byte sequencer.
module wsfe_queue import wsfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t stat
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  assign head_cmd        = mem_r[rd_ptr_r];
  assign stat.full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign stat.head_valid = (count_r != '0);
  assign do_pop          = pop && stat.head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/wsfe_back.sv]
// Back end: expands queued commands into frame bytes and holds the output register.
module wsfe_back import wsfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      head_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic [3:0] idx_r, idx_nxt;

  logic       load;
  logic [3:0] ext_n;
  logic [3:0] hdr_n;
  logic [3:0] j;
  logic [3:0] k;
  logic [6:0] code;
  logic [7:0] hbyte;
  logic       hdr_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;

  always_comb begin
    ext_n    = ext_len(head_cmd.len_sel);
    hdr_n    = 4'd2 + ext_n + (head_cmd.mask ? 4'd4 : 4'd0);
    hdr_last = (idx_r == hdr_n - 4'd1);
    j        = idx_r - 4'd2;
    k        = idx_r - 4'd2 - ext_n;
    unique case (head_cmd.len_sel)
      LEN_16:  code = LEN_CODE_16;
      LEN_64:  code = LEN_CODE_64;
      default: code = head_cmd.plen[6:0];
    endcase

    if (idx_r == 4'd0) begin
      hbyte = FIN_BIT | {4'd0, head_cmd.opcode};
    end else if (idx_r == 4'd1) begin
      hbyte = {head_cmd.mask, code};
    end else if (idx_r < 4'd2 + ext_n) begin
      if (head_cmd.len_sel == LEN_16) begin
        hbyte = j[0] ? head_cmd.plen[7:0] : head_cmd.plen[15:8];
      end else begin
        // upper four length bytes are zero, then the length msb first
        hbyte = (j < 4'd4) ? 8'd0 : key_byte(head_cmd.plen, j[1:0]);
      end
    end else begin
      hbyte = key_byte(head_cmd.key, k[1:0]);
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    q_pop         = 1'b0;

    if (load) begin
      out_valid_nxt = q_stat.head_valid;
      if (q_stat.head_valid) begin
        unique case (head_cmd.kind)
          CMD_PAY: begin
            q_pop = 1'b1;
            out_data_nxt = '{out_byte: head_cmd.data, byte_kind: KIND_PAY,
                             error_too_long: 1'b0, run_last: 1'b1,
                             frame_end: head_cmd.fend};
          end
          CMD_ERR: begin
            q_pop = 1'b1;
            out_data_nxt = '{out_byte: 8'd0, byte_kind: KIND_NONE,
                             error_too_long: 1'b1, run_last: 1'b1,
                             frame_end: 1'b0};
          end
          default: begin
            q_pop   = hdr_last;
            idx_nxt = hdr_last ? 4'd0 : idx_r + 4'd1;
            out_data_nxt = '{out_byte: hbyte, byte_kind: KIND_HDR,
                             error_too_long: 1'b0, run_last: hdr_last,
                             frame_end: hdr_last && head_cmd.fend};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/websocket_frame_encoder.sv]
// Top level of the WebSocket frame encoder: front end, command queue and byte sequencer.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): a frame-start word carries opcode,
//   payload length and mask key; a payload word carries one raw byte. A word is taken
//   at a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_data): one frame byte per word, header
//   bytes first, then masked payload bytes; a refused frame gives one error word.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   mask_enable, index 1 is max_frame_bytes; cfg_ready is always high. Write only
//   while the block is idle.
// Timing:
//   A word taken is written into the command queue, and its first result is then loaded
//   into the output register. Payload words stream at one per cycle while out_stall is
//   low. A frame start gives 2 to 14 header bytes, one per cycle in the byte sequencer;
//   the front end keeps taking words meanwhile until the four-entry command queue fills.
// Reset (rst_n low, synchronous): no frame open, masking off, max_frame_bytes 8192,
//   queue and output register empty.
// Stall: while out_stall is high the output word holds; the queue absorbs up to four
//   more input words, then in_stall rises.
module websocket_frame_encoder import wsfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  q_stat_t q_stat;
  logic    q_push;
  cmd_t    q_cmd;
  logic    q_pop;
  cmd_t    head_cmd;

  // classify input words and keep frame state (length left, key, phase)
  wsfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // decouple the two sides so a long header burst does not hold the input
  wsfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // drain commands into bytes, one output word per cycle while out_stall is low
  wsfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_cmd  (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.head_valid)
    else $error("command popped from empty queue");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_too_long) |->
      (out_data.run_last && out_data.byte_kind == KIND_NONE && !out_data.frame_end))
    else $error("malformed refusal word");

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_end) |-> out_data.run_last)
    else $error("frame end on a word that is not the last of its input");
`endif

endmodule
